// ----- design/ihex16_pkg.sv -----
// Shared types, codes and helpers of the INHX16 record parser.
package ihex16_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_REC    = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // Status codes
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_CSUM    = 4'd1;
    localparam logic [3:0] ST_NO_EOL  = 4'd2;
    localparam logic [3:0] ST_BAD_LEN = 4'd3;
    localparam logic [3:0] ST_BAD_ADR = 4'd4;
    localparam logic [3:0] ST_BAD_TYP = 4'd5;
    localparam logic [3:0] ST_BAD_HEX = 4'd6;
    localparam logic [3:0] ST_NO_DATA = 4'd7;
    localparam logic [3:0] ST_NO_END  = 4'd8;

    // Record types
    localparam logic [7:0] REC_DATA  = 8'd0;
    localparam logic [7:0] REC_EOF   = 8'd1;
    localparam logic [7:0] REC_SEG   = 8'd2;
    localparam logic [7:0] REC_SSTA  = 8'd3;
    localparam logic [7:0] REC_LIN   = 8'd4;
    localparam logic [7:0] REC_LSTA  = 8'd5;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [15:0] data_word;
        logic [3:0]  status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic result_t make_result(input logic [1:0] kind,
                                            input logic [31:0] address,
                                            input logic [15:0] data_word,
                                            input logic [3:0] status);
        result_t r;
        r.kind      = kind;
        r.address   = address;
        r.data_word = data_word;
        r.status    = status;
        return r;
    endfunction

    function automatic hex_digit_t decode_hex(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ----- design/ihex16_core.sv -----
// Parser state registers and the per-character next-state and result logic.
module ihex16_core
    import ihex16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        check_en,
    input  logic        step,
    input  logic [7:0]  char_in,
    input  logic        end_of_input,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [2:0] {
        PH_LINE, PH_SKIP, PH_HEAD, PH_BODY, PH_EOL, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        nib_valid_reg, nib_valid_next;
    logic [3:0]  nib_hold_reg, nib_hold_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  wcount_reg, wcount_next;
    logic [15:0] waddr_reg, waddr_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] base_reg, base_next;
    logic        seg_reg, seg_next;
    logic [7:0]  hbyte_reg, hbyte_next;
    logic [31:0] start_reg, start_next;
    logic        data_seen_reg, data_seen_next;
    logic        halted_reg, halted_next;

    hex_digit_t  hx;
    logic [7:0]  byte_val;
    logic [15:0] swapped;
    logic [17:0] offset;
    logic [31:0] data_addr;
    logic [21:0] seg_start;

    always_comb begin
        hx        = decode_hex(char_in);
        byte_val  = {nib_hold_reg, hx.value};
        swapped   = {byte_val, hbyte_reg};
        offset    = {1'b0, waddr_reg, 1'b0} + {9'd0, pos_reg[8:1], 1'b0};
        data_addr = seg_reg ? (base_reg + {16'd0, offset[15:0]})
                            : (base_reg + {14'd0, offset});
        seg_start = {({1'b0, start_reg[31:16], 4'd0} + {5'd0, start_reg[15:0]}), 1'b0};

        phase_next     = phase_reg;
        nib_valid_next = nib_valid_reg;
        nib_hold_next  = nib_hold_reg;
        pos_next       = pos_reg;
        wcount_next    = wcount_reg;
        waddr_next     = waddr_reg;
        rtype_next     = rtype_reg;
        sum_next       = sum_reg;
        base_next      = base_reg;
        seg_next       = seg_reg;
        hbyte_next     = hbyte_reg;
        start_next     = start_reg;
        data_seen_next = data_seen_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = make_result(KIND_DATA, 32'd0, 16'd0, ST_OK);

        if (!halted_reg && phase_reg != PH_DONE) begin
            case (phase_reg)
                PH_LINE, PH_SKIP: begin
                    if (end_of_input) begin
                        res_valid = 1'b1;
                        if (!data_seen_reg) begin
                            halted_next = 1'b1;
                            res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_NO_DATA);
                        end else begin
                            phase_next = PH_DONE;
                            res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_NO_END);
                        end
                    end else if (char_in == CHAR_NL) begin
                        phase_next = PH_LINE;
                    end else if (phase_reg == PH_LINE) begin
                        if (char_in == CHAR_COLON) begin
                            sum_next       = 8'd0;
                            pos_next       = 9'd0;
                            nib_valid_next = 1'b0;
                            phase_next     = PH_HEAD;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_EOL: begin
                    res_valid   = 1'b1;
                    halted_next = 1'b1;
                    phase_next  = PH_LINE;
                    if (check_en && sum_reg != 8'd0) begin
                        res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_CSUM);
                    end else if (end_of_input || char_in != CHAR_NL) begin
                        res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_NO_EOL);
                    end else begin
                        case (rtype_reg)
                            REC_DATA: begin
                                halted_next    = 1'b0;
                                data_seen_next = 1'b1;
                                res = make_result(KIND_REC, 32'd0, 16'd0, ST_OK);
                            end
                            REC_EOF: begin
                                if (wcount_reg != 8'd0) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_LEN);
                                end else if (waddr_reg != 16'd0) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_ADR);
                                end else if (!data_seen_reg) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_NO_DATA);
                                end else begin
                                    halted_next = 1'b0;
                                    phase_next  = PH_DONE;
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_OK);
                                end
                            end
                            REC_SEG, REC_LIN: begin
                                if (wcount_reg != 8'd1) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_LEN);
                                end else if (waddr_reg != 16'd0) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_ADR);
                                end else begin
                                    halted_next = 1'b0;
                                    if (rtype_reg == REC_SEG) begin
                                        base_next = {11'd0, start_reg[15:0], 5'd0};
                                        seg_next  = 1'b1;
                                    end else begin
                                        base_next = {start_reg[14:0], 17'd0};
                                        seg_next  = 1'b0;
                                    end
                                    res = make_result(KIND_REC, 32'd0, 16'd0, ST_OK);
                                end
                            end
                            REC_SSTA, REC_LSTA: begin
                                if (wcount_reg != 8'd2) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_LEN);
                                end else if (waddr_reg != 16'd0) begin
                                    res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_ADR);
                                end else begin
                                    halted_next = 1'b0;
                                    if (rtype_reg == REC_SSTA) begin
                                        res = make_result(KIND_START, {10'd0, seg_start},
                                                          16'd0, ST_OK);
                                    end else begin
                                        res = make_result(KIND_START, {start_reg[30:0], 1'b0},
                                                          16'd0, ST_OK);
                                    end
                                end
                            end
                            default: begin
                                res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_TYP);
                            end
                        endcase
                    end
                end
                PH_HEAD, PH_BODY: begin
                    if (end_of_input || !hx.valid) begin
                        res_valid   = 1'b1;
                        halted_next = 1'b1;
                        res = make_result(KIND_REPORT, 32'd0, 16'd0, ST_BAD_HEX);
                    end else if (!nib_valid_reg) begin
                        nib_hold_next  = hx.value;
                        nib_valid_next = 1'b1;
                    end else begin
                        nib_valid_next = 1'b0;
                        sum_next       = sum_reg + byte_val;
                        if (phase_reg == PH_HEAD) begin
                            pos_next = pos_reg + 9'd1;
                            case (pos_reg[1:0])
                                2'd0: wcount_next = byte_val;
                                2'd1: waddr_next  = {byte_val, 8'd0};
                                2'd2: waddr_next  = {waddr_reg[15:8], byte_val};
                                default: begin
                                    rtype_next = byte_val;
                                    phase_next = PH_BODY;
                                    pos_next   = 9'd0;
                                end
                            endcase
                        end else if (pos_reg >= {wcount_reg, 1'b0}) begin
                            phase_next = PH_EOL;
                        end else begin
                            pos_next = pos_reg + 9'd1;
                            if (!pos_reg[0]) begin
                                hbyte_next = byte_val;
                            end else begin
                                // first word loads the start value, second shifts it in
                                if (pos_reg == 9'd1) begin
                                    start_next = {16'd0, swapped};
                                end else if (pos_reg == 9'd3) begin
                                    start_next = {start_reg[15:0], swapped};
                                end
                                if (rtype_reg == REC_DATA) begin
                                    res_valid = 1'b1;
                                    res = make_result(KIND_DATA, data_addr,
                                                      {hbyte_reg, byte_val}, ST_OK);
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LINE;
            nib_valid_reg <= 1'b0;
            nib_hold_reg  <= 4'd0;
            pos_reg       <= 9'd0;
            wcount_reg    <= 8'd0;
            waddr_reg     <= 16'd0;
            rtype_reg     <= 8'd0;
            sum_reg       <= 8'd0;
            base_reg      <= 32'd0;
            seg_reg       <= 1'b0;
            hbyte_reg     <= 8'd0;
            start_reg     <= 32'd0;
            data_seen_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            nib_valid_reg <= nib_valid_next;
            nib_hold_reg  <= nib_hold_next;
            pos_reg       <= pos_next;
            wcount_reg    <= wcount_next;
            waddr_reg     <= waddr_next;
            rtype_reg     <= rtype_next;
            sum_reg       <= sum_next;
            base_reg      <= base_next;
            seg_reg       <= seg_next;
            hbyte_reg     <= hbyte_next;
            start_reg     <= start_next;
            data_seen_reg <= data_seen_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

// ----- design/ihex16_out_reg.sv -----
// Result register in front of the master-side stream.
module ihex16_out_reg
    import ihex16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res_in,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // address[31:0], data_word[47:32], status[51:48], zero
    output logic [1:0]  m_tuser    // kind[1:0]
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.data_word, res_reg.address};
    assign m_tuser  = res_reg.kind;

endmodule

// ----- design/intel_hex16_record_parser.sv -----
// Top level of the INHX16 hex record parser: input register, parser core, result register.
//
// Feed the hex file one ASCII character per request on the s_ channel
// (s_tdata = character, s_tlast = end of input, character then ignored).
// Results leave on the m_ channel: m_tuser carries the kind (data word,
// start address, record end, error/end report), m_tdata the byte address,
// the data word and the status. Data words leave as soon as their second
// byte is decoded; commit them only when the record-end result carries
// status ok, since the checksum is judged at the line's newline.
// A character taken into the input register is decoded when the result register
// is free, and its result, if any, is loaded there and shows on m_tvalid.
// Throughput: one character per cycle while the result register is free, set by
// the single-pass decode between the input register and the result register.
// cfg_valid/cfg_data write the checksum enable (reset value 1); write it
// only while no character is in flight. cfg_ready is always high.
// Reset (aresetn low, synchronous) clears the parser to line start, linear
// mode, base zero, and drops any held request or result.
// When m_tready is low with a result held, the held character stalls and
// s_tready drops; characters that give no result still flow while the
// result register is free. After an error the block drops all input.
module intel_hex16_record_parser
    import ihex16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in[7:0]
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // address[31:0], data_word[47:32], status[51:48], zero
    output logic [1:0]  m_tuser    // kind[1:0]
);

    logic       check_en_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_eoi_reg;
    logic       out_free;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign cfg_ready = 1'b1;

    // Advance the held character whenever the result register can take its result.
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (step) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            check_en_reg <= 1'b1;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid) begin
                check_en_reg <= cfg_data;
            end
        end
    end

    // Hold the accepted character until the core consumes it.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    ihex16_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .check_en     (check_en_reg),
        .step         (step),
        .char_in      (in_char_reg),
        .end_of_input (in_eoi_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    ihex16_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res_in   (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the INHX16 hex record parser: hex file stimulus, word predictor.
`timescale 1ns / 1ps

module tb_top;
    import ihex16_pkg::*;

    localparam int HOLD_CYCLES = 300;   // one long receiver hold-off to back up the parser

    // Where the predictor stands within the current line
    typedef enum logic [2:0] {AT_LINE, IN_SKIP, IN_HEAD, IN_BODY, AT_EOL, FINISHED} parse_phase_t;

    // Tracks the parser's line state, predicts the result of every accepted character
    // and holds the results still owed by the block.
    class word_stream_board;
        logic         csum_check;
        parse_phase_t phase;
        logic         nib_ok;
        logic [3:0]   nib;
        logic [8:0]   byte_pos;
        logic [7:0]   word_cnt;
        logic [15:0]  word_adr;
        logic [7:0]   rec_type;
        logic [7:0]   sum;
        logic [31:0]  base;
        logic         segmented;
        logic [7:0]   hi_byte;
        logic [31:0]  start_val;
        logic         data_seen;
        logic         halted;
        result_t      awaited_results[$];
        int           failures;

        function new();
            csum_check = 1'b1;
            phase      = AT_LINE;
            nib_ok     = 1'b0;
            nib        = '0;
            byte_pos   = '0;
            word_cnt   = '0;
            word_adr   = '0;
            rec_type   = '0;
            sum        = '0;
            base       = '0;
            segmented  = 1'b0;
            hi_byte    = '0;
            start_val  = '0;
            data_seen  = 1'b0;
            halted     = 1'b0;
            failures   = 0;
        endfunction

        static function int hex_value(input logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
            return -1;
        endfunction

        function bit report(input logic [1:0] kind, input logic [31:0] addr,
                            input logic [15:0] word, input logic [3:0] status,
                            output result_t r);
            r.kind      = kind;
            r.address   = addr;
            r.data_word = word;
            r.status    = status;
            return 1'b1;
        endfunction

        // Any error freezes the parser until reset
        function bit stop_with(input logic [3:0] status, output result_t r);
            halted = 1'b1;
            return report(KIND_REPORT, 32'd0, 16'd0, status, r);
        endfunction

        function bit end_of_stream(output result_t r);
            if (!data_seen) return stop_with(ST_NO_DATA, r);
            phase = FINISHED;
            return report(KIND_REPORT, 32'd0, 16'd0, ST_NO_END, r);
        endfunction

        // Character after the checksum byte: judge the whole line
        function bit close_line(input logic [7:0] ch, input logic eoi, output result_t r);
            logic [31:0] seg_start;
            if (csum_check && sum != 8'd0) return stop_with(ST_CSUM, r);
            if (eoi || ch != CHAR_NL) return stop_with(ST_NO_EOL, r);
            phase = AT_LINE;
            case (rec_type)
                REC_DATA: begin
                    data_seen = 1'b1;
                    return report(KIND_REC, 32'd0, 16'd0, ST_OK, r);
                end
                REC_EOF: begin
                    if (word_cnt != 8'd0) return stop_with(ST_BAD_LEN, r);
                    if (word_adr != 16'd0) return stop_with(ST_BAD_ADR, r);
                    if (!data_seen) return stop_with(ST_NO_DATA, r);
                    phase = FINISHED;
                    return report(KIND_REPORT, 32'd0, 16'd0, ST_OK, r);
                end
                REC_SEG, REC_LIN: begin
                    if (word_cnt != 8'd1) return stop_with(ST_BAD_LEN, r);
                    if (word_adr != 16'd0) return stop_with(ST_BAD_ADR, r);
                    segmented = (rec_type == REC_SEG);
                    if (segmented) base = {11'd0, start_val[15:0], 5'd0};
                    else base = {start_val[14:0], 17'd0};
                    return report(KIND_REC, 32'd0, 16'd0, ST_OK, r);
                end
                REC_SSTA, REC_LSTA: begin
                    if (word_cnt != 8'd2) return stop_with(ST_BAD_LEN, r);
                    if (word_adr != 16'd0) return stop_with(ST_BAD_ADR, r);
                    seg_start = {12'd0, start_val[31:16], 4'd0} + {16'd0, start_val[15:0]};
                    if (rec_type == REC_SSTA)
                        return report(KIND_START, {seg_start[30:0], 1'b0}, 16'd0, ST_OK, r);
                    return report(KIND_START, {start_val[30:0], 1'b0}, 16'd0, ST_OK, r);
                end
                default: return stop_with(ST_BAD_TYP, r);
            endcase
        endfunction

        // Advance the line state by one character; 1 when it owes a result
        function bit decode_char(input logic [7:0] ch, input logic eoi, output result_t r);
            int          v;
            logic [7:0]  b;
            logic [31:0] off;
            logic [31:0] addr;
            r = '0;
            if (halted || phase == FINISHED) return 1'b0;
            case (phase)
                AT_LINE: begin
                    if (eoi) return end_of_stream(r);
                    if (ch == CHAR_NL) return 1'b0;
                    if (ch == CHAR_COLON) begin
                        sum      = 8'd0;
                        byte_pos = 9'd0;
                        nib_ok   = 1'b0;
                        phase    = IN_HEAD;
                    end else begin
                        phase = IN_SKIP;
                    end
                    return 1'b0;
                end
                IN_SKIP: begin
                    if (eoi) return end_of_stream(r);
                    if (ch == CHAR_NL) phase = AT_LINE;
                    return 1'b0;
                end
                AT_EOL: return close_line(ch, eoi, r);
                default: ;
            endcase

            v = eoi ? -1 : hex_value(ch);
            if (v < 0) return stop_with(ST_BAD_HEX, r);
            if (!nib_ok) begin
                nib    = v[3:0];
                nib_ok = 1'b1;
                return 1'b0;
            end
            nib_ok = 1'b0;
            b      = {nib, v[3:0]};
            sum    = sum + b;

            if (phase == IN_HEAD) begin
                case (byte_pos)
                    9'd0: word_cnt = b;
                    9'd1: word_adr = {b, 8'h00};
                    9'd2: word_adr[7:0] = b;
                    default: begin
                        rec_type = b;
                        phase    = IN_BODY;
                        byte_pos = 9'd0;
                        return 1'b0;
                    end
                endcase
                byte_pos = byte_pos + 9'd1;
                return 1'b0;
            end

            // Body: data pairs, then the checksum byte
            if (byte_pos >= {word_cnt, 1'b0}) begin
                phase = AT_EOL;
                return 1'b0;
            end
            if (!byte_pos[0]) begin
                hi_byte  = b;
                byte_pos = byte_pos + 9'd1;
                return 1'b0;
            end
            if (byte_pos == 9'd1) start_val = {16'd0, b, hi_byte};
            else if (byte_pos == 9'd3) start_val = {start_val[15:0], b, hi_byte};
            off = {15'd0, word_adr, 1'b0} + {23'd0, byte_pos[8:1], 1'b0};
            byte_pos = byte_pos + 9'd1;
            if (rec_type != REC_DATA) return 1'b0;
            addr = segmented ? base + {16'd0, off[15:0]} : base + off;
            return report(KIND_DATA, addr, {hi_byte, b}, ST_OK, r);
        endfunction

        function void note_char(input logic [7:0] ch, input logic eoi);
            result_t r;
            if (decode_char(ch, eoi, r)) awaited_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input logic [1:0] kind, input logic [31:0] addr,
                                   input logic [15:0] word, input logic [3:0] status);
            result_t want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d address %h word %h status %0d",
                       kind, addr, word, status);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", {30'd0, want.kind}, {30'd0, kind});
            compare_field("address", want.address, addr);
            compare_field("data_word", {16'd0, want.data_word}, {16'd0, word});
            compare_field("status", {28'd0, want.status}, {28'd0, status});
        endfunction

        function void close_out();
            if (awaited_results.size() != 0) begin
                $error("%0d results never arrived", awaited_results.size());
                failures += awaited_results.size();
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    word_stream_board board = new();

    bit         calm_tail    = 1'b0;   // last part of the run: no idling on either side
    bit         hold_results = 1'b0;   // ask the receiver for its long hold-off
    int         chars_sent   = 0;
    logic [7:0] line_buf[$];           // characters of the line being built
    logic [7:0] payload[$];            // data bytes of the next record

    intel_hex16_record_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Safety net: a hung handshake ends the run
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Check every result taken by the receiver against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            board.check_result(m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[51:48]);
        end
    end

    // Receiver: random ready bursts and stalls, and one long hold-off
    // on request so the result register stays full and the parser stops taking input.
    initial begin : result_sink
        int span;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_results) begin
                m_tready     <= 1'b0;
                span         = HOLD_CYCLES;
                hold_results = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                span     = $urandom_range(1, 11);
            end else begin
                m_tready <= 1'b1;
                span     = $urandom_range(1, 24);
            end
            repeat (span) @(posedge aclk);
        end
    end

    // Offer one character request, maybe after an idle burst; return once it is taken
    task automatic send_char(input logic [7:0] c, input logic eoi);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        board.note_char(c, eoi);
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
        line_buf.delete();
    endtask

    // Two hex digits, letters in random case
    task automatic put_hex(input logic [7:0] b);
        logic [3:0] n;
        for (int k = 1; k >= 0; k--) begin
            n = k ? b[7:4] : b[3:0];
            if (n < 4'd10) line_buf.push_back(8'h30 + {4'd0, n});
            else if ($urandom_range(0, 1) == 1) line_buf.push_back(8'h37 + {4'd0, n});
            else line_buf.push_back(8'h57 + {4'd0, n});
        end
    endtask

    task automatic fill_payload(input int n);
        repeat (n) payload.push_back(8'($urandom));
    endtask

    // Colon, header, the queued payload and the checksum; no newline
    task automatic put_record(input logic [7:0] rtype, input logic [7:0] count,
                              input logic [15:0] adr, input bit sum_ok);
        logic [7:0] csum;
        csum = count + adr[15:8] + adr[7:0] + rtype;
        line_buf.push_back(CHAR_COLON);
        put_hex(count);
        put_hex(adr[15:8]);
        put_hex(adr[7:0]);
        put_hex(rtype);
        foreach (payload[i]) begin
            put_hex(payload[i]);
            csum = csum + payload[i];
        end
        csum = 8'd0 - csum;
        if (!sum_ok) csum = csum + 8'($urandom_range(1, 255));
        put_hex(csum);
        payload.delete();
    endtask

    task automatic record_line(input logic [7:0] rtype, input logic [7:0] count,
                               input logic [15:0] adr, input bit sum_ok);
        put_record(rtype, count, adr, sum_ok);
        line_buf.push_back(CHAR_NL);
        send_line();
    endtask

    // Start of a line the parser skips: anything but a colon or a newline first
    task automatic junk_prefix();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CHAR_COLON || c == CHAR_NL);
        line_buf.push_back(c);
        repeat ($urandom_range(0, 10)) begin
            do c = 8'($urandom); while (c == CHAR_NL);
            line_buf.push_back(c);
        end
    endtask

    // One well-formed line; loose_sum lets half the records carry a wrong checksum
    task automatic random_line(input bit loose_sum);
        int          pick;
        bit          good;
        logic [7:0]  count;
        logic [15:0] adr;
        logic [15:0] w;
        pick = $urandom_range(0, 99);
        good = !loose_sum || ($urandom_range(0, 1) == 1);
        if (pick < 8) begin
            // blank line: the newline alone
        end else if (pick < 18) begin
            junk_prefix();
        end else if (pick < 78) begin
            // mostly short records, now and then a longer one
            count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                                : 8'($urandom_range(0, 6));
            adr = ($urandom_range(0, 3) == 0) ? {8'hFF, 8'($urandom)} : 16'($urandom);
            fill_payload(2 * int'(count));
            put_record(REC_DATA, count, adr, good);
        end else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                default: w = 16'($urandom);
            endcase
            payload.push_back(w[15:8]);
            payload.push_back(w[7:0]);
            put_record(($urandom_range(0, 1) == 1) ? REC_SEG : REC_LIN, 8'd1, 16'd0, good);
        end else begin
            fill_payload(4);
            put_record(($urandom_range(0, 1) == 1) ? REC_SSTA : REC_LSTA, 8'd2, 16'd0, good);
        end
        line_buf.push_back(CHAR_NL);
        send_line();
    endtask

    // Drain, let any result-free characters settle, then write the checksum enable
    task automatic write_csum_check(input logic en);
        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid <= 1'b0;
        board.csum_check = en;
    endtask

    initial begin : stimulus
        logic [7:0]  c;
        logic [7:0]  rtype;
        logic [7:0]  count;
        logic [7:0]  proper_count;
        int          k;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, checksum checked: blank and skipped lines, count and
        // address extremes, 32-bit wrap in linear mode, 16-bit wrap in segmented
        // mode, both start address types, back to linear with base zero.
        write_csum_check(1'b1);
        line_buf.push_back(CHAR_NL);
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'h7F);
        line_buf.push_back(CHAR_NL);
        send_line();
        record_line(REC_DATA, 8'd0, 16'd0, 1'b1);
        payload.push_back(8'hFF);
        payload.push_back(8'hFF);
        record_line(REC_DATA, 8'd1, 16'hFFFF, 1'b1);
        payload.push_back(8'hFF);
        payload.push_back(8'hFF);
        record_line(REC_LIN, 8'd1, 16'd0, 1'b1);
        fill_payload(6);
        record_line(REC_DATA, 8'd3, 16'hFFFF, 1'b1);
        payload.push_back(8'hFF);
        payload.push_back(8'hFF);
        record_line(REC_SEG, 8'd1, 16'd0, 1'b1);
        fill_payload(4);
        record_line(REC_DATA, 8'd2, 16'hFFFF, 1'b1);
        repeat (4) payload.push_back(8'hFF);
        record_line(REC_SSTA, 8'd2, 16'd0, 1'b1);
        fill_payload(4);
        record_line(REC_LSTA, 8'd2, 16'd0, 1'b1);
        payload.push_back(8'h00);
        payload.push_back(8'h00);
        record_line(REC_LIN, 8'd1, 16'd0, 1'b1);
        payload.push_back(8'h00);
        payload.push_back(8'h00);
        payload.push_back(8'hFF);
        payload.push_back(8'hFF);
        record_line(REC_DATA, 8'd2, 16'd0, 1'b1);

        // Checksum off: a wrong sum must pass, then random lines with mixed sums
        write_csum_check(1'b0);
        fill_payload(4);
        record_line(REC_DATA, 8'd2, 16'($urandom), 1'b0);
        while (chars_sent < 650) random_line(1'b1);

        // Checksum on, with the long receiver hold-off early in this stretch
        write_csum_check(1'b1);
        hold_results = 1'b1;
        while (chars_sent < 1150) random_line(1'b0);

        write_csum_check(1'b0);
        while (chars_sent < 1400) random_line(1'b1);

        // Last part: no idling, checksum on, then a final line or end of input that ends parsing
        write_csum_check(1'b1);
        calm_tail = 1'b1;
        while (chars_sent < 1600) random_line(1'b0);

        case ($urandom_range(0, 8))
            0: record_line(REC_EOF, 8'd0, 16'd0, 1'b1);
            1: send_char(8'($urandom), 1'b1);
            2: begin
                // end of input inside a skipped line
                junk_prefix();
                send_line();
                send_char(8'($urandom), 1'b1);
            end
            3: begin
                fill_payload(4);
                record_line(REC_DATA, 8'd2, 16'($urandom), 1'b0);
            end
            4: begin
                // something other than a newline after the checksum
                fill_payload(2);
                put_record(REC_DATA, 8'd1, 16'($urandom), 1'b1);
                send_line();
                if ($urandom_range(0, 1) == 1) begin
                    send_char(8'($urandom), 1'b1);
                end else begin
                    do c = 8'($urandom); while (c == CHAR_NL);
                    send_char(c, 1'b0);
                end
            end
            5, 6: begin
                // control record with a wrong word count or a nonzero address
                rtype = 8'($urandom_range(1, 5));
                if (rtype == REC_EOF) proper_count = 8'd0;
                else if (rtype == REC_SEG || rtype == REC_LIN) proper_count = 8'd1;
                else proper_count = 8'd2;
                count = proper_count;
                if ($urandom_range(0, 1) == 1) begin
                    do count = 8'($urandom_range(0, 4)); while (count == proper_count);
                end
                fill_payload(2 * int'(count));
                record_line(rtype, count,
                            (count == proper_count) ? 16'($urandom_range(1, 65535)) : 16'd0,
                            1'b1);
            end
            7: begin
                count = 8'($urandom_range(0, 3));
                fill_payload(2 * int'(count));
                record_line(8'($urandom_range(6, 255)), count, 16'($urandom), 1'b1);
            end
            default: begin
                // cut a record short at a hex position, then a non-hex character
                // or end of input
                count = 8'($urandom_range(0, 3));
                fill_payload(2 * int'(count));
                put_record(REC_DATA, count, 16'($urandom), 1'b1);
                k = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > k) void'(line_buf.pop_back());
                send_line();
                if ($urandom_range(0, 1) == 1) begin
                    send_char(8'($urandom), 1'b1);
                end else begin
                    do c = 8'($urandom); while (word_stream_board::hex_value(c) >= 0);
                    send_char(c, 1'b0);
                end
            end
        endcase

        // Parsing has ended: anything further must be dropped without a result
        repeat (6) send_char(8'($urandom), 1'($urandom));

        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        board.close_out();
        if (board.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- intel_hex16_record_parser.f -----
design/ihex16_pkg.sv
design/ihex16_core.sv
design/ihex16_out_reg.sv
design/intel_hex16_record_parser.sv
tb/tb_top.sv
